@@ rtl/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper package
// Command word passed from the classifier to the expander, and the character
// constants that both sides use.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

	typedef logic [1:0] kind_t;

	localparam kind_t K_NONE  = 2'd0;
	localparam kind_t K_RAW   = 2'd1;
	localparam kind_t K_SHORT = 2'd2;
	localparam kind_t K_UESC  = 2'd3;

	// One input word turns into: pre replacement escapes, at most one main unit,
	// then post replacement escapes. RAW carries up to four bytes, first in [7:0].
	typedef struct packed {
		logic [2:0]  pre;
		kind_t       kind;
		logic [2:0]  len;
		logic [31:0] data;
		logic [1:0]  post;
		logic        text_end;
	} jse_cmd_t;

	localparam logic [7:0] CH_BSLASH   = 8'h5C;
	localparam logic [7:0] CH_QUOTE    = 8'h22;
	localparam logic [7:0] CH_U        = 8'h75;
	localparam logic [7:0] CH_F        = 8'h66;
	localparam logic [7:0] CH_D        = 8'h64;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_A_LESS10 = 8'h57;
	localparam logic [7:0] CH_B        = 8'h62;
	localparam logic [7:0] CH_N        = 8'h6E;
	localparam logic [7:0] CH_R        = 8'h72;
	localparam logic [7:0] CH_T        = 8'h74;

	localparam logic [7:0] CTL_BS    = 8'h08;
	localparam logic [7:0] CTL_HT    = 8'h09;
	localparam logic [7:0] CTL_LF    = 8'h0A;
	localparam logic [7:0] CTL_FF    = 8'h0C;
	localparam logic [7:0] CTL_CR    = 8'h0D;
	localparam logic [7:0] CTL_LIMIT = 8'h20;

	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_LO    = 8'hC2;
	localparam logic [7:0] LEAD2_HI    = 8'hDF;
	localparam logic [7:0] LEAD3_LO    = 8'hE0;
	localparam logic [7:0] LEAD3_HI    = 8'hEF;
	localparam logic [7:0] LEAD4_LO    = 8'hF0;
	localparam logic [7:0] LEAD4_HI    = 8'hF4;
	localparam logic [7:0] LEAD_SURR   = 8'hED;
	localparam logic [7:0] SEC_A0      = 8'hA0;
	localparam logic [7:0] SEC_90      = 8'h90;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = CH_ZERO + {4'd0, nib};
		end else begin
			r = CH_A_LESS10 + {4'd0, nib};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/json_string_escaper_utf8.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper with UTF-8 validation
// Takes one byte a word and produces the escaped string body a byte a word.
// ----------------------------------------------------------------------------
// The first output byte of a word passes through the command queue and the
// expander's command registers into the registered output stage. The expander
// sends one output byte per cycle while the output is taken; a word is accepted
// every cycle while the command queue has room, and words that expand to several
// bytes fill it and apply backpressure. Reset clears the sequence state, the queue and the output.
`default_nettype none

module json_string_escaper_utf8
	import jse_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_run,
	output logic            text_done
);

	logic     push_valid, push_ready, pop_valid, pop_ready;
	jse_cmd_t push_data, pop_data;

	jse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_data   (push_data)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	jse_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.text_done   (text_done)
	);

endmodule

`default_nettype wire

@@ rtl/jse_front.sv @@
// ----------------------------------------------------------------------------
// JSON escaper classifier
// Tracks the open UTF-8 sequence and turns each input word into at most one command.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_front
	import jse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	output logic            push_valid,
	input  wire logic       push_ready,
	output jse_cmd_t        push_data
);

	logic [7:0] pend0_q, pend1_q, pend2_q;
	logic [1:0] count_q;
	logic [2:0] exp_len_q;

	logic       accept;
	logic       cont, sec_ok, fresh, hold_wr;
	logic [1:0] nxt_count;
	logic [2:0] nxt_exp;
	logic       lead_wr;
	jse_cmd_t   cmd;

	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd       = '0;
		nxt_count = count_q;
		nxt_exp   = exp_len_q;
		fresh     = 1'b0;
		hold_wr   = 1'b0;
		lead_wr   = 1'b0;
		cont      = in_byte[7:6] == 2'b10;
		sec_ok    = 1'b1;
		if (pend0_q == LEAD3_LO && in_byte < SEC_A0) sec_ok = 1'b0;
		if (pend0_q == LEAD_SURR && in_byte >= SEC_A0) sec_ok = 1'b0;
		if (pend0_q == LEAD4_LO && in_byte < SEC_90) sec_ok = 1'b0;
		if (pend0_q == LEAD4_HI && in_byte >= SEC_90) sec_ok = 1'b0;

		if (count_q == 2'd0) begin
			fresh = 1'b1;
		end else if (!(cont && (count_q > 2'd1 || sec_ok))) begin
			cmd.pre = {1'b0, count_q};
			fresh   = 1'b1;
		end else if ({1'b0, count_q} + 3'd1 >= exp_len_q) begin
			cmd.kind        = K_RAW;
			cmd.len         = {1'b0, count_q} + 3'd1;
			cmd.data[7:0]   = pend0_q;
			cmd.data[15:8]  = (count_q > 2'd1) ? pend1_q : in_byte;
			cmd.data[23:16] = (count_q > 2'd2) ? pend2_q : in_byte;
			cmd.data[31:24] = in_byte;
			nxt_count       = 2'd0;
			nxt_exp         = 3'd0;
		end else begin
			hold_wr   = 1'b1;
			nxt_count = count_q + 2'd1;
		end

		if (fresh) begin
			nxt_count = 2'd0;
			nxt_exp   = 3'd0;
			if (in_byte < ASCII_LIMIT) begin
				cmd.kind = K_SHORT;
				unique case (in_byte)
					CH_QUOTE:  cmd.data[7:0] = CH_QUOTE;
					CH_BSLASH: cmd.data[7:0] = CH_BSLASH;
					CTL_BS:    cmd.data[7:0] = CH_B;
					CTL_FF:    cmd.data[7:0] = CH_F;
					CTL_LF:    cmd.data[7:0] = CH_N;
					CTL_CR:    cmd.data[7:0] = CH_R;
					CTL_HT:    cmd.data[7:0] = CH_T;
					default: begin
						cmd.data[7:0] = in_byte;
						if (in_byte < CTL_LIMIT) begin
							cmd.kind = K_UESC;
						end else begin
							cmd.kind = K_RAW;
							cmd.len  = 3'd1;
						end
					end
				endcase
			end else if (in_byte >= LEAD2_LO && in_byte <= LEAD2_HI) begin
				lead_wr = 1'b1; nxt_count = 2'd1; nxt_exp = 3'd2;
			end else if (in_byte >= LEAD3_LO && in_byte <= LEAD3_HI) begin
				lead_wr = 1'b1; nxt_count = 2'd1; nxt_exp = 3'd3;
			end else if (in_byte >= LEAD4_LO && in_byte <= LEAD4_HI) begin
				lead_wr = 1'b1; nxt_count = 2'd1; nxt_exp = 3'd4;
			end else begin
				// An invalid lead is replaced straight away.
				cmd.pre = cmd.pre + 3'd1;
			end
		end

		// Anything still held at the end of the text is cut off.
		if (end_of_text && nxt_count != 2'd0) begin
			cmd.post  = nxt_count;
			nxt_count = 2'd0;
			nxt_exp   = 3'd0;
		end
		cmd.text_end = end_of_text;
	end

	assign push_data  = cmd;
	assign push_valid = in_valid &&
		(cmd.pre != 3'd0 || cmd.kind != K_NONE || cmd.post != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= 2'd0;
			exp_len_q <= 3'd0;
		end else if (accept) begin
			count_q   <= nxt_count;
			exp_len_q <= nxt_exp;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && lead_wr) pend0_q <= in_byte;
		if (accept && hold_wr && count_q == 2'd1) pend1_q <= in_byte;
		if (accept && hold_wr && count_q == 2'd2) pend2_q <= in_byte;
	end

endmodule

`default_nettype wire

@@ rtl/jse_queue.sv @@
// ----------------------------------------------------------------------------
// JSON escaper command queue
// Small register FIFO that decouples the classifier from the expander.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_queue
	import jse_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push_valid,
	output logic          push_ready,
	input  wire jse_cmd_t push_data,
	output logic          pop_valid,
	input  wire logic     pop_ready,
	output jse_cmd_t      pop_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	jse_cmd_t      mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] fill_q;
	logic          do_push, do_pop;

	assign push_ready = fill_q != FULL_CNT;
	assign pop_valid  = fill_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) fill_q <= fill_q + 1'b1;
			else if (do_pop && !do_push) fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

`default_nettype wire

@@ rtl/jse_back.sv @@
// ----------------------------------------------------------------------------
// JSON escaper expander
// Walks one command a byte at a time into the registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_back
	import jse_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     pop_valid,
	output logic          pop_ready,
	input  wire jse_cmd_t pop_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output logic [7:0]    out_byte,
	output logic          last_of_run,
	output logic          text_done
);

	logic        busy_q;
	logic [2:0]  pre_q;
	kind_t       kind_q;
	logic [2:0]  len_q;
	logic [31:0] data_q;
	logic [1:0]  post_q;
	logic        end_q;
	logic [2:0]  sub_q;

	logic        out_valid_q, last_q, done_q;
	logic [7:0]  out_byte_q;

	logic        in_pre, in_main, step, unit_end, cmd_end, take;
	logic [2:0]  unit_len;
	logic [7:0]  cur_byte, esc_byte;

	assign in_pre  = pre_q != 3'd0;
	assign in_main = !in_pre && kind_q != K_NONE;
	assign step    = busy_q && (!out_valid_q || out_ready);

	// Byte of the replacement escape for U+FFFD.
	always_comb begin
		unique case (sub_q) inside
			3'd0:             esc_byte = CH_BSLASH;
			3'd1:             esc_byte = CH_U;
			3'd2, 3'd3, 3'd4: esc_byte = CH_F;
			default:          esc_byte = CH_D;
		endcase
	end

	always_comb begin
		unit_len = 3'd6;
		cur_byte = esc_byte;
		if (in_main) begin
			unique case (kind_q)
				K_RAW: begin
					unit_len = len_q;
					cur_byte = data_q[{sub_q[1:0], 3'b000} +: 8];
				end
				K_SHORT: begin
					unit_len = 3'd2;
					cur_byte = (sub_q == 3'd0) ? CH_BSLASH : data_q[7:0];
				end
				K_UESC: begin
					unit_len = 3'd6;
					unique case (sub_q) inside
						3'd0:       cur_byte = CH_BSLASH;
						3'd1:       cur_byte = CH_U;
						3'd2, 3'd3: cur_byte = CH_ZERO;
						3'd4:       cur_byte = hex_char(data_q[7:4]);
						default:    cur_byte = hex_char(data_q[3:0]);
					endcase
				end
				default: begin
					unit_len = 3'd6;
					cur_byte = esc_byte;
				end
			endcase
		end
	end

	assign unit_end = sub_q == unit_len - 3'd1;
	assign cmd_end  = unit_end && (in_pre ?
		(pre_q == 3'd1 && kind_q == K_NONE && post_q == 2'd0) :
		(in_main ? post_q == 2'd0 : post_q == 2'd1));

	// The next word is loaded as the last byte of the current one leaves.
	assign take      = pop_valid && (!busy_q || (step && cmd_end));
	assign pop_ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) busy_q <= 1'b1;
			else if (step && cmd_end) busy_q <= 1'b0;
			if (step) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pre_q  <= pop_data.pre;
			kind_q <= pop_data.kind;
			len_q  <= pop_data.len;
			data_q <= pop_data.data;
			post_q <= pop_data.post;
			end_q  <= pop_data.text_end;
			sub_q  <= 3'd0;
		end else if (step) begin
			if (unit_end) begin
				sub_q <= 3'd0;
				if (in_pre) pre_q <= pre_q - 3'd1;
				else if (in_main) kind_q <= K_NONE;
				else post_q <= post_q - 2'd1;
			end else begin
				sub_q <= sub_q + 3'd1;
			end
		end
		if (step) begin
			out_byte_q <= cur_byte;
			last_q     <= cmd_end;
			done_q     <= cmd_end && end_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign last_of_run = last_q;
	assign text_done   = done_q;

endmodule

`default_nettype wire

@@ tb/sv/json_escape_checker.sv @@
// ----------------------------------------------------------------------------
// JSON escaper output checker
// Watches both channels of the escaper. Every accepted input word is escaped
// by a local predictor, and every accepted output word is compared with the
// oldest escaped byte still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module json_escape_checker
	import jse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] out_byte,
	input  wire logic       last_of_run,
	input  wire logic       text_done,
	output int              fail_count,
	output int              bytes_owed
);

	localparam logic [127:0] HEX_DIGITS  = "0123456789abcdef";
	localparam logic [15:0]  REPLACEMENT = 16'hFFFD;

	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       text_end;
	} esc_byte_t;

	esc_byte_t  owed_q[$];
	esc_byte_t  run_q[$];
	logic [7:0] held [3];
	logic [1:0] held_count;
	logic [2:0] seq_len;

	function automatic void add_out(input logic [7:0] c);
		esc_byte_t e;
		e.ch       = c;
		e.run_end  = 1'b0;
		e.text_end = 1'b0;
		run_q.push_back(e);
	endfunction

	function automatic void add_unicode_escape(input logic [15:0] cp);
		add_out(CH_BSLASH);
		add_out(CH_U);
		for (int k = 3; k >= 0; k--) begin
			add_out(HEX_DIGITS[8 * (15 - int'(cp[4 * k +: 4])) +: 8]);
		end
	endfunction

	// Each held byte of a rejected sequence becomes one replacement character.
	function automatic void replace_held();
		for (int k = 0; k < int'(held_count); k++) begin
			add_unicode_escape(REPLACEMENT);
		end
		held_count = 2'd0;
		seq_len    = 3'd0;
	endfunction

	function automatic logic [2:0] utf8_length(input logic [7:0] b);
		logic [2:0] n;
		n = 3'd0;
		if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			n = 3'd2;
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			n = 3'd3;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			n = 3'd4;
		end
		return n;
	endfunction

	// Overlong, surrogate and beyond-plane-sixteen forms show in the second byte.
	function automatic logic second_in_range(input logic [7:0] lead, input logic [7:0] s);
		logic ok;
		ok = 1'b1;
		if (lead == LEAD3_LO && s < SEC_A0) begin
			ok = 1'b0;
		end else if (lead == LEAD_SURR && s >= SEC_A0) begin
			ok = 1'b0;
		end else if (lead == LEAD4_LO && s < SEC_90) begin
			ok = 1'b0;
		end else if (lead == LEAD4_HI && s >= SEC_90) begin
			ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic void escape_fresh(input logic [7:0] b);
		logic [2:0] n;
		if (b < ASCII_LIMIT) begin
			case (b)
				CH_QUOTE, CH_BSLASH: begin
					add_out(CH_BSLASH);
					add_out(b);
				end
				CTL_BS: begin
					add_out(CH_BSLASH);
					add_out(CH_B);
				end
				CTL_FF: begin
					add_out(CH_BSLASH);
					add_out(CH_F);
				end
				CTL_LF: begin
					add_out(CH_BSLASH);
					add_out(CH_N);
				end
				CTL_CR: begin
					add_out(CH_BSLASH);
					add_out(CH_R);
				end
				CTL_HT: begin
					add_out(CH_BSLASH);
					add_out(CH_T);
				end
				default: begin
					if (b < CTL_LIMIT) begin
						add_unicode_escape({8'h00, b});
					end else begin
						add_out(b);
					end
				end
			endcase
		end else begin
			n = utf8_length(b);
			if (n == 3'd0) begin
				add_unicode_escape(REPLACEMENT);
			end else begin
				held[0]    = b;
				held_count = 2'd1;
				seq_len    = n;
			end
		end
	endfunction

	function automatic void escape_word(input logic [7:0] b, input logic eot);
		logic      ok;
		esc_byte_t tail;
		run_q.delete();
		if (held_count == 2'd0) begin
			escape_fresh(b);
		end else begin
			ok = (b[7:6] == 2'b10) && (held_count > 2'd1 || second_in_range(held[0], b));
			if (!ok) begin
				replace_held();
				escape_fresh(b);
			end else if (int'(held_count) + 1 >= int'(seq_len)) begin
				for (int k = 0; k < int'(held_count); k++) begin
					add_out(held[k]);
				end
				add_out(b);
				held_count = 2'd0;
				seq_len    = 3'd0;
			end else begin
				held[held_count] = b;
				held_count       = held_count + 2'd1;
			end
		end
		if (eot && held_count != 2'd0) begin
			replace_held();
		end
		if (run_q.size() > 0) begin
			tail          = run_q.pop_back();
			tail.run_end  = 1'b1;
			tail.text_end = eot;
			run_q.push_back(tail);
		end
		foreach (run_q[k]) begin
			owed_q.push_back(run_q[k]);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		esc_byte_t want;
		if (!arst_n) begin
			owed_q.delete();
			held_count = 2'd0;
			seq_len    = 3'd0;
			fail_count = 0;
			bytes_owed = 0;
		end else begin
			// An input word cannot leave in the cycle it arrives, so predicting
			// first never hides an early output.
			if (in_valid && in_ready) begin
				escape_word(in_byte, end_of_text);
			end
			if (out_valid && out_ready) begin
				if (owed_q.size() == 0) begin
					$display("%0t: unexpected output word: byte %h last_of_run %b text_done %b",
						$time, out_byte, last_of_run, text_done);
					fail_count++;
				end else begin
					want = owed_q.pop_front();
					if (out_byte !== want.ch || last_of_run !== want.run_end ||
							text_done !== want.text_end) begin
						$display("%0t: output mismatch: expected byte %h last_of_run %b text_done %b, got byte %h last_of_run %b text_done %b",
							$time, want.ch, want.run_end, want.text_end,
							out_byte, last_of_run, text_done);
						fail_count++;
					end
				end
			end
			bytes_owed = owed_q.size();
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// JSON escaper testbench
// Feeds texts of ASCII, control characters and UTF-8 sequences, both well
// formed and broken, under random bursts and output stalls, and leaves the
// checking to the checker module beside the escaper.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import jse_pkg::*;

	localparam int HALF_PERIOD     = 5;
	localparam int RESET_CYCLES    = 9;
	localparam int RANDOM_WORDS    = 135;
	localparam int HOLD_AT         = 60;
	localparam int PAUSE_AT        = 130;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int IDLE_LIMIT      = 2000;
	localparam int DRAIN_CYCLES    = 10;
	localparam int DIRECTED_WORDS  = 27;

	// Printable and control characters, bad leads, good sequences at the
	// boundary of their ranges, a rejected second byte, a bad continuation,
	// and a sequence cut off by the end of the text.
	localparam logic [7:0] DIRECTED [DIRECTED_WORDS] = '{
		8'h00, 8'h1F, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h22, 8'h5C, 8'h7F,
		8'h80, 8'hFF,
		8'hC2, 8'h80,
		8'hE0, 8'hA0, 8'h80,
		8'hF4, 8'h8F, 8'hBF, 8'hBF,
		8'hE0, 8'h9F,
		8'hC3, 8'h41,
		8'hF0, 8'h90
	};

	typedef struct packed {
		logic [7:0] value;
		logic       eot;
	} text_word_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic [7:0] in_byte     = 8'h00;
	logic       end_of_text = 1'b0;
	logic       out_ready   = 1'b0;
	logic       hold_req    = 1'b0;
	wire logic       in_ready;
	wire logic       out_valid;
	wire logic [7:0] out_byte;
	wire logic       last_of_run;
	wire logic       text_done;
	int         fail_count;
	int         bytes_owed;
	int         idle_cycles = 0;
	text_word_t text_q[$];

	always #HALF_PERIOD clk = ~clk;

	json_string_escaper_utf8 u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.text_done   (text_done)
	);

	json_escape_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.text_done   (text_done),
		.fail_count  (fail_count),
		.bytes_owed  (bytes_owed)
	);

	task automatic add_word(input logic [7:0] v);
		text_q.push_back('{v, 1'b0});
	endtask

	task automatic close_text();
		text_word_t w;
		w     = text_q.pop_back();
		w.eot = 1'b1;
		text_q.push_back(w);
	endtask

	// A well-formed sequence of the given length, of which only the first
	// keep bytes are added.
	task automatic add_utf8(input int len, input int keep);
		logic [7:0] lead;
		logic [7:0] lo;
		logic [7:0] hi;
		case (len)
			2: lead = 8'($urandom_range(LEAD2_LO, LEAD2_HI));
			3: begin
				if ($urandom_range(0, 2) == 0) begin
					lead = $urandom_range(0, 1) ? LEAD3_LO : LEAD_SURR;
				end else begin
					lead = 8'($urandom_range(LEAD3_LO, LEAD3_HI));
				end
			end
			default: lead = 8'($urandom_range(LEAD4_LO, LEAD4_HI));
		endcase
		lo = 8'h80;
		hi = 8'hBF;
		if (lead == LEAD3_LO) begin
			lo = SEC_A0;
		end else if (lead == LEAD_SURR) begin
			hi = SEC_A0 - 8'd1;
		end else if (lead == LEAD4_LO) begin
			lo = SEC_90;
		end else if (lead == LEAD4_HI) begin
			hi = SEC_90 - 8'd1;
		end
		add_word(lead);
		if (keep > 1) begin
			add_word(8'($urandom_range(lo, hi)));
		end
		for (int k = 2; k < keep; k++) begin
			add_word(8'($urandom_range(8'h80, 8'hBF)));
		end
	endtask

	// Receiver: stretches of steady readiness, random or patterned stalls, and one long
	// hold-off when the sender asks for it.
	initial begin
		int  len;
		int  mode;
		logic held_off;
		held_off = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_req && !held_off) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				held_off = 1'b1;
			end else begin
				len  = $urandom_range(10, 60);
				mode = $urandom_range(0, 2);
				for (int i = 0; i < len && !(hold_req && !held_off); i++) begin
					@(negedge clk);
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						default: out_ready <= (i % 5) < 3;
					endcase
				end
			end
		end
	end

	// Sender and verdict.
	initial begin
		int         pick;
		int         units;
		int         len;
		int         burst;
		int         gap;
		logic [7:0] lead;
		text_word_t w;

		for (int i = 0; i < DIRECTED_WORDS; i++) begin
			add_word(DIRECTED[i]);
			if (i == 9 || i == DIRECTED_WORDS - 1) begin
				close_text();
			end
		end
		while (text_q.size() < DIRECTED_WORDS + RANDOM_WORDS) begin
			units = $urandom_range(1, 10);
			repeat (units) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					add_word(8'($urandom_range(8'h20, 8'h7E)));
				end else if (pick < 35) begin
					len = $urandom_range(0, 32);
					add_word(len == 32 ? 8'h7F : 8'(len));
				end else if (pick < 40) begin
					add_word($urandom_range(0, 1) ? CH_QUOTE : CH_BSLASH);
				end else if (pick < 65) begin
					len = $urandom_range(2, 4);
					add_utf8(len, len);
				end else if (pick < 75) begin
					len = $urandom_range(2, 4);
					add_utf8(len, $urandom_range(1, len - 1));
				end else if (pick < 85) begin
					// Second byte outside the range its lead allows.
					case ($urandom_range(0, 3))
						0: begin
							lead = LEAD3_LO;
							add_word(lead);
							add_word(8'($urandom_range(8'h80, SEC_A0 - 8'd1)));
						end
						1: begin
							lead = LEAD_SURR;
							add_word(lead);
							add_word(8'($urandom_range(SEC_A0, 8'hBF)));
						end
						2: begin
							lead = LEAD4_LO;
							add_word(lead);
							add_word(8'($urandom_range(8'h80, SEC_90 - 8'd1)));
						end
						default: begin
							lead = LEAD4_HI;
							add_word(lead);
							add_word(8'($urandom_range(SEC_90, 8'hBF)));
						end
					endcase
					if ($urandom_range(0, 1)) begin
						add_word(8'($urandom_range(8'h80, 8'hBF)));
					end
				end else begin
					add_word(8'($urandom_range(0, 255)));
				end
			end
			close_text();
		end

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		burst = $urandom_range(1, 20);
		for (int idx = 0; idx < text_q.size(); idx++) begin
			if (idx == HOLD_AT) begin
				hold_req = 1'b1;
			end
			if (idx == PAUSE_AT) begin
				@(negedge clk);
				in_valid <= 1'b0;
				wait (bytes_owed == 0);
			end
			w = text_q[idx];
			@(negedge clk);
			in_valid    <= 1'b1;
			in_byte     <= w.value;
			end_of_text <= w.eot;
			do @(posedge clk); while (!in_ready);
			burst--;
			if (burst == 0) begin
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					@(negedge clk);
					in_valid <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end
				burst = $urandom_range(1, 20);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;
		wait (bytes_owed == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("** json_string_escaper_utf8: PASSED **");
		end else begin
			$display("** json_string_escaper_utf8: FAILED **");
		end
		$finish;
	end

	// A run that stops moving words in either direction is stuck.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("** json_string_escaper_utf8: FAILED **");
			$finish;
		end
	end

endmodule

`default_nettype wire
